// File: design/gsap_pkg.sv
// gsap_pkg: shared constants, types and microcode table of the goal subset
// antichain pruner. No dependencies.
package gsap_pkg;

    localparam int NUM_GOALS_DEF   = 32;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MASK_W          = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int COUNT_W         = 7;

    localparam logic [CFG_IDX_W-1:0] REG_HARD_GOAL_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALL_SOFT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRUNE_ENABLE   = 2'd2;

    typedef logic [3:0] step_t;

    localparam step_t STEP_CLEAR  = 4'd0;
    localparam step_t STEP_WAIT   = 4'd1;
    localparam step_t STEP_SCAN1  = 4'd2;
    localparam step_t STEP_DRAIN1 = 4'd3;
    localparam step_t STEP_DECIDE = 4'd4;
    localparam step_t STEP_SCAN2  = 4'd5;
    localparam step_t STEP_DRAIN2 = 4'd6;
    localparam step_t STEP_INSERT = 4'd7;
    localparam step_t STEP_EMIT   = 4'd8;

    typedef enum logic [2:0] {
        COND_NONE      = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NOT_LAST  = 3'd2,
        COND_NO_START  = 3'd3,
        COND_NO_INSERT = 3'd4
    } cond_t;

    typedef struct packed {
        logic  accept;
        logic  rd_en;
        logic  scan_prune;
        logic  addr_inc;
        logic  addr_clr;
        logic  clr_wr;
        logic  insert;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t c;
        c = '{accept: 1'b0, rd_en: 1'b0, scan_prune: 1'b0, addr_inc: 1'b0,
              addr_clr: 1'b0, clr_wr: 1'b0, insert: 1'b0, emit: 1'b0,
              cond: COND_NONE, target: STEP_WAIT};
        case (step)
            STEP_CLEAR:
            begin
                c.clr_wr   = 1'b1;
                c.addr_inc = 1'b1;
                c.cond     = COND_NOT_LAST;
                c.target   = STEP_CLEAR;
            end
            STEP_WAIT:
            begin
                c.accept = 1'b1;
                c.cond   = COND_NO_START;
                c.target = STEP_WAIT;
            end
            STEP_SCAN1:
            begin
                c.rd_en    = 1'b1;
                c.addr_inc = 1'b1;
                c.cond     = COND_NOT_LAST;
                c.target   = STEP_SCAN1;
            end
            STEP_DRAIN1:
            begin
                c.cond = COND_NONE;
            end
            STEP_DECIDE:
            begin
                c.addr_clr = 1'b1;
                c.cond     = COND_NO_INSERT;
                c.target   = STEP_EMIT;
            end
            STEP_SCAN2:
            begin
                c.rd_en      = 1'b1;
                c.scan_prune = 1'b1;
                c.addr_inc   = 1'b1;
                c.cond       = COND_NOT_LAST;
                c.target     = STEP_SCAN2;
            end
            STEP_DRAIN2:
            begin
                c.cond = COND_NONE;
            end
            STEP_INSERT:
            begin
                c.insert = 1'b1;
            end
            STEP_EMIT:
            begin
                c.emit   = 1'b1;
                c.cond   = COND_ALWAYS;
                c.target = STEP_WAIT;
            end
            default:
            begin
                c.cond   = COND_ALWAYS;
                c.target = STEP_WAIT;
            end
        endcase
        return c;
    endfunction

endpackage

// File: design/goal_subset_antichain_pruner.sv
// goal_subset_antichain_pruner: microcoded prune decision and antichain table.
// Depends on gsap_pkg (microcode table, register indexes, widths).

// After reset the block sweeps the table once to clear it, one entry per cycle,
// so busy stays high and no start is taken until the sweep is done.
// A transfer starts when start is high and busy is low. The sequencer first
// scans all entries for cover checks (through the single table read port); if
// the satisfied mask is eligible for insertion it scans again to drop subsets
// and then writes the new set into a free entry, if one is found. done pulses
// for one cycle, and the results stay on the outputs until the next done.
// busy falls in the cycle done rises, so the next start may coincide with done.
module goal_subset_antichain_pruner #(
    parameter int NUM_GOALS   = gsap_pkg::NUM_GOALS_DEF,
    parameter int TABLE_DEPTH = gsap_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [gsap_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsap_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [gsap_pkg::MASK_W-1:0]     reachable_goals,
    input  logic [gsap_pkg::MASK_W-1:0]     satisfied_goals,
    output logic                            done,
    output logic                            prune,
    output logic                            hard_unreachable,
    output logic                            covered,
    output logic                            table_changed,
    output logic                            table_overflow,
    output logic [gsap_pkg::COUNT_W-1:0]    entry_count
);
    import gsap_pkg::*;

    localparam int GOAL_BITS = (NUM_GOALS < MASK_W) ? NUM_GOALS : MASK_W;
    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

    typedef logic [GOAL_BITS-1:0] goals_t;
    typedef logic [GOAL_BITS:0]   word_t;

    // table storage: valid bit on top of the goal set
    word_t mem [TABLE_DEPTH];

    goals_t                hard_mask_reg;
    logic                  all_soft_reg;
    logic                  prune_enable_reg;

    step_t                 pc_reg, pc_next;
    logic [IDX_W-1:0]      addr_reg;
    logic [CNT_W-1:0]      count_reg;
    goals_t                reach_reg, sat_reg;
    logic                  covered_reg, super_reg, free_found_reg;
    logic                  changed_reg, overflow_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  rd_vld_reg, rd_prune_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    word_t                 rd_word_reg;
    logic                  done_reg;
    logic                  prune_reg, unreach_reg, cov_out_reg;
    logic                  chg_out_reg, ovf_out_reg;
    logic [COUNT_W-1:0]    count_out_reg;

    ctrl_t                 ctrl;
    logic                  jump;
    logic                  addr_last;
    logic                  accepted;
    goals_t                hard;
    logic                  hard_sat_ok;
    logic                  ent_valid;
    goals_t                ent_set;
    logic                  removed;
    logic                  is_free;
    logic                  insert_do;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    word_t                 wr_data;

    assign ctrl        = ucode(pc_reg);
    assign addr_last   = (addr_reg == IDX_W'(TABLE_DEPTH - 1));
    assign accepted    = ctrl.accept && start;
    assign hard        = all_soft_reg ? '0 : hard_mask_reg;
    assign hard_sat_ok = ((hard & sat_reg) == hard);
    assign ent_valid   = rd_word_reg[GOAL_BITS];
    assign ent_set     = rd_word_reg[GOAL_BITS-1:0];
    assign removed     = rd_vld_reg && rd_prune_reg && ent_valid
                         && ((ent_set & ~sat_reg) == '0);
    assign is_free     = rd_vld_reg && rd_prune_reg && (!ent_valid || removed);
    assign insert_do   = ctrl.insert && free_found_reg;

    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS:    jump = 1'b1;
            COND_NOT_LAST:  jump = !addr_last;
            COND_NO_START:  jump = !start;
            COND_NO_INSERT: jump = !(hard_sat_ok && !super_reg);
            default:        jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.target : step_t'(pc_reg + 4'd1);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (ctrl.clr_wr)
        begin
            wr_en = 1'b1;
        end
        else if (removed)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
        end
        else if (insert_do)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
            wr_data = {1'b1, sat_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_word_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hard_mask_reg    <= '0;
            all_soft_reg     <= 1'b0;
            prune_enable_reg <= 1'b1;
            pc_reg           <= STEP_CLEAR;
            addr_reg         <= '0;
            count_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            rd_prune_reg     <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_HARD_GOAL_MASK: hard_mask_reg    <= cfg_data[GOAL_BITS-1:0];
                    REG_ALL_SOFT:       all_soft_reg     <= cfg_data[0];
                    REG_PRUNE_ENABLE:   prune_enable_reg <= cfg_data[0];
                    default:            hard_mask_reg    <= hard_mask_reg;
                endcase
            end
            pc_reg <= pc_next;
            if (accepted || ctrl.addr_clr)
            begin
                addr_reg <= '0;
            end
            else if (ctrl.addr_inc)
            begin
                addr_reg <= IDX_W'(addr_reg + 1'b1);
            end
            if (removed)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
            else if (insert_do)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            rd_vld_reg   <= ctrl.rd_en;
            rd_prune_reg <= ctrl.scan_prune;
            done_reg     <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= addr_reg;
        if (accepted)
        begin
            reach_reg      <= reachable_goals[GOAL_BITS-1:0];
            sat_reg        <= satisfied_goals[GOAL_BITS-1:0];
            covered_reg    <= 1'b0;
            super_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            changed_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
        end
        else
        begin
            if (rd_vld_reg && !rd_prune_reg && ent_valid)
            begin
                if ((reach_reg & ~ent_set) == '0)
                begin
                    covered_reg <= 1'b1;
                end
                if ((sat_reg & ~ent_set) == '0)
                begin
                    super_reg <= 1'b1;
                end
            end
            if (is_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
            if (ctrl.insert)
            begin
                changed_reg  <= free_found_reg;
                overflow_reg <= !free_found_reg;
            end
        end
        if (ctrl.emit)
        begin
            unreach_reg   <= ((hard & reach_reg) != hard);
            cov_out_reg   <= covered_reg;
            prune_reg     <= (((hard & reach_reg) != hard) || covered_reg)
                             && prune_enable_reg;
            chg_out_reg   <= changed_reg;
            ovf_out_reg   <= overflow_reg;
            count_out_reg <= COUNT_W'(count_reg);
        end
    end

    assign busy             = (pc_reg != STEP_WAIT);
    assign done             = done_reg;
    assign prune            = prune_reg;
    assign hard_unreachable = unreach_reg;
    assign covered          = cov_out_reg;
    assign table_changed    = chg_out_reg;
    assign table_overflow   = ovf_out_reg;
    assign entry_count      = count_out_reg;

endmodule

// File: design/gsap_checker.sv
// gsap_checker: port-level assertions for goal_subset_antichain_pruner.
// Depends on gsap_pkg; bound to the top level at the end of this file.
module gsap_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_wr_en,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic                            prune,
    input logic                            hard_unreachable,
    input logic                            covered,
    input logic                            table_changed,
    input logic                            table_overflow,
    input logic [gsap_pkg::COUNT_W-1:0]    entry_count
);
    import gsap_pkg::*;

    // a transfer in flight keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after transfer start");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_prune_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done && prune |-> (hard_unreachable || covered))
        else $error("prune without a cause");

    a_chg_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(table_changed && table_overflow))
        else $error("insert and overflow in the same transfer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= COUNT_W'(TABLE_DEPTH_DEF)))
        else $error("entry count above table depth");

endmodule

bind goal_subset_antichain_pruner gsap_checker u_gsap_checker (.*);

// File: tb/goal_subset_antichain_pruner_tb.sv
// goal_subset_antichain_pruner_tb: self-checking bench for the goal subset antichain
// pruner. It keeps its own antichain table and register copy and checks every result.
// Depends on gsap_pkg and the goal_subset_antichain_pruner design.
module goal_subset_antichain_pruner_tb;
    import gsap_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam logic [MASK_W-1:0] GOAL_MASK = (NUM_GOALS_DEF >= MASK_W) ? {MASK_W{1'b1}}
        : ({MASK_W{1'b1}} >> (MASK_W - NUM_GOALS_DEF));
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               prune;
        logic               hard_unreachable;
        logic               covered;
        logic               table_changed;
        logic               table_overflow;
        logic [COUNT_W-1:0] entry_count;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic [MASK_W-1:0]     reachable_goals;
    logic [MASK_W-1:0]     satisfied_goals;
    logic                  done;
    logic                  prune;
    logic                  hard_unreachable;
    logic                  covered;
    logic                  table_changed;
    logic                  table_overflow;
    logic [COUNT_W-1:0]    entry_count;

    verdict_t          verdict_q[$];
    logic [MASK_W-1:0] sat_hist[$];
    logic [MASK_W-1:0] tbl_set[DEPTH];
    logic              tbl_valid[DEPTH];
    logic [MASK_W-1:0] hard_reg;
    logic              soft_reg;
    logic              prune_reg;
    int                fail_cnt;
    int                n_items;
    int                n_inserts;
    int                n_overflows;
    int                n_covered;
    int                n_pruned;

    goal_subset_antichain_pruner uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Set A contains set B when (B & ~A) == 0.
    function automatic verdict_t predict_verdict(input logic [MASK_W-1:0] reach_in,
                                                 input logic [MASK_W-1:0] sat_in);
        logic [MASK_W-1:0] reach;
        logic [MASK_W-1:0] sat;
        logic [MASK_W-1:0] hard;
        logic              has_super;
        int                free_slot;
        int                cnt;
        int                i;
        verdict_t          v;
        reach = reach_in & GOAL_MASK;
        sat = sat_in & GOAL_MASK;
        hard = soft_reg ? '0 : (hard_reg & GOAL_MASK);
        v = '0;
        has_super = 1'b0;
        v.hard_unreachable = (hard & reach) != hard;
        for (i = 0; i < DEPTH; i++)
        begin
            if (tbl_valid[i] && (reach & ~tbl_set[i]) == '0)
                v.covered = 1'b1;
            if (tbl_valid[i] && (sat & ~tbl_set[i]) == '0)
                has_super = 1'b1;
        end
        if ((hard & sat) == hard && !has_super)
        begin
            free_slot = -1;
            for (i = 0; i < DEPTH; i++)
                if (tbl_valid[i] && (tbl_set[i] & ~sat) == '0)
                    tbl_valid[i] = 1'b0;
            for (i = 0; i < DEPTH; i++)
                if (!tbl_valid[i] && free_slot < 0)
                    free_slot = i;
            if (free_slot >= 0)
            begin
                tbl_set[free_slot] = sat;
                tbl_valid[free_slot] = 1'b1;
                v.table_changed = 1'b1;
            end
            else
                v.table_overflow = 1'b1;
        end
        cnt = 0;
        for (i = 0; i < DEPTH; i++)
            if (tbl_valid[i])
                cnt++;
        v.entry_count = cnt[COUNT_W-1:0];
        v.prune = (v.hard_unreachable | v.covered) & prune_reg;
        return v;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && done)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("done pulse with no transfer outstanding");
                fail_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                check_field("prune", want.prune, prune);
                check_field("hard_unreachable", want.hard_unreachable, hard_unreachable);
                check_field("covered", want.covered, covered);
                check_field("table_changed", want.table_changed, table_changed);
                check_field("table_overflow", want.table_overflow, table_overflow);
                check_field("entry_count", want.entry_count, entry_count);
            end
        end
    end

    task automatic send_goals(input logic [MASK_W-1:0] reach, input logic [MASK_W-1:0] sat);
        verdict_t v;
        @(negedge clk);
        start <= 1'b1;
        reachable_goals <= reach;
        satisfied_goals <= sat;
        do
            @(posedge clk);
        while (busy);
        v = predict_verdict(reach, sat);
        verdict_q = {verdict_q, v};
        n_items++;
        n_inserts += v.table_changed;
        n_overflows += v.table_overflow;
        n_covered += v.covered;
        n_pruned += v.prune;
        sat_hist = {sat_hist, sat};
        if (sat_hist.size() > 32)
            void'(sat_hist.pop_front());
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0 || busy);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_HARD_GOAL_MASK: hard_reg = data[MASK_W-1:0];
            REG_ALL_SOFT:       soft_reg = data[0];
            REG_PRUNE_ENABLE:   prune_reg = data[0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic sender_pause(input int pct);
        int gap;
        gap = 0;
        if (pct > 0 && $urandom_range(99, 0) < 4)
            gap = $urandom_range(150, 1);
        while ($urandom_range(99, 0) < pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    function automatic logic [MASK_W-1:0] sparse_mask(input int bits);
        logic [MASK_W-1:0] m;
        int                i;
        m = '0;
        for (i = 0; i < bits; i++)
            m[$urandom_range(MASK_W-1, 0)] = 1'b1;
        return m;
    endfunction

    function automatic logic [MASK_W-1:0] window_bits();
        logic [MASK_W-1:0] w;
        w = $urandom_range(255, 0);
        return w << $urandom_range(24, 0);
    endfunction

    // random 10-bit pattern with a fixed number of ones
    function automatic logic [9:0] pick_bits(input int ones);
        logic [9:0] w;
        logic       t;
        int         i;
        int         j;
        w = (10'd1 << ones) - 10'd1;
        for (i = 9; i > 0; i--)
        begin
            j = $urandom_range(i, 0);
            t = w[i];
            w[i] = w[j];
            w[j] = t;
        end
        return w;
    endfunction

    // mostly related masks so that cover, subsumption and insert all happen often
    task automatic gen_goal_pair(output logic [MASK_W-1:0] r, output logic [MASK_W-1:0] s);
        logic [MASK_W-1:0] a;
        logic [MASK_W-1:0] b;
        logic [MASK_W-1:0] c;
        logic [MASK_W-1:0] h;
        logic [MASK_W-1:0] eff;
        int                sel;
        a = $urandom();
        b = $urandom();
        c = $urandom();
        eff = soft_reg ? '0 : hard_reg;
        h = sat_hist[$urandom_range(sat_hist.size() - 1, 0)];
        sel = $urandom_range(99, 0);
        if (sel < 10)
        begin
            r = a;
            s = b;
        end
        else if (sel < 20)
        begin
            s = a | b | c;
            r = a & b;
        end
        else if (sel < 70)
        begin
            s = window_bits();
            if ($urandom_range(99, 0) < 80)
                s |= eff;
            case ($urandom_range(2, 0))
                0:       r = s & a;
                1:       r = window_bits() | eff;
                default: r = h & a;
            endcase
        end
        else
        begin
            case ($urandom_range(2, 0))
                0:
                begin
                    s = h & a;
                    r = h;
                end
                1:
                begin
                    s = h | (32'd1 << $urandom_range(31, 0));
                    r = s;
                end
                default:
                begin
                    s = h | window_bits();
                    r = h | eff;
                end
            endcase
        end
    endtask

    task automatic test_reset_state();
        wait_idle();
        send_goals(32'h0, 32'h0);
        send_goals(32'h0, 32'h0);
    endtask

    task automatic test_mask_extremes();
        send_goals(32'hFFFF_FFFF, 32'h0000_00FF);
        send_goals(32'h0000_0001, 32'h0000_00F0);
        send_goals(32'hFFFF_FFFF, 32'hF000_0000);
        send_goals(32'h0000_0000, 32'hF000_00FF);
    endtask

    task automatic test_hard_goals();
        wait_idle();
        write_reg(REG_HARD_GOAL_MASK, 32'h0000_0300);
        send_goals(32'h0000_0100, 32'h0000_0001);
        send_goals(32'h0000_0300, 32'h0000_0300);
        send_goals(32'h0000_0200, 32'h0000_0200);
    endtask

    task automatic test_all_soft();
        wait_idle();
        write_reg(REG_ALL_SOFT, 32'hFFFF_FFFF);
        send_goals(32'h0000_0000, 32'h0000_0400);
    endtask

    task automatic test_prune_disable();
        wait_idle();
        write_reg(REG_PRUNE_ENABLE, 32'hFFFF_FFFE);
        send_goals(32'h0000_0001, 32'h0000_0001);
        wait_idle();
        write_reg(REG_ALL_SOFT, 32'h0);
        write_reg(REG_HARD_GOAL_MASK, 32'hFFFF_FFFF);
        send_goals(32'h7FFF_FFFF, 32'h0000_0000);
    endtask

    task automatic test_unmapped_index();
        wait_idle();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_goals(32'h0000_00FF, 32'h0000_0FFF);
        wait_idle();
        write_reg(REG_UNUSED, 32'h0);
        send_goals(32'h0000_00FF, 32'h0000_0FFF);
        wait_idle();
        write_reg(REG_HARD_GOAL_MASK, 32'h0);
        write_reg(REG_PRUNE_ENABLE, 32'h1);
    endtask

    // incomparable 5-of-10 sets on bits 16..25 fill the table; 6-of-10 sets then
    // displace their subsets while full, and the whole window clears them at the end
    task automatic test_table_overflow();
        logic [9:0] w;
        int         guard;
        int         base_ovf;
        base_ovf = n_overflows;
        for (guard = 0; guard < 400 && n_overflows - base_ovf < 6; guard++)
        begin
            w = pick_bits((n_overflows > base_ovf && $urandom_range(99, 0) < 30) ? 6 : 5);
            sender_pause(14);
            send_goals(($urandom_range(1, 0) != 0) ? ({6'd0, w, 16'd0} & $urandom()) : $urandom(),
                       {6'd0, w, 16'd0});
        end
        send_goals($urandom(), 32'h03FF_0000);
    endtask

    task automatic test_random_traffic(input int n_trans, input int idle_pct,
                                       input logic [MASK_W-1:0] hard, input logic soft_en,
                                       input logic pr);
        logic [MASK_W-1:0] r;
        logic [MASK_W-1:0] s;
        int                k;
        wait_idle();
        write_reg(REG_HARD_GOAL_MASK, hard);
        write_reg(REG_ALL_SOFT, ($urandom() & ~32'd1) | {31'd0, soft_en});
        write_reg(REG_PRUNE_ENABLE, ($urandom() & ~32'd1) | {31'd0, pr});
        for (k = 0; k < n_trans; k++)
        begin
            if (k == n_trans / 2)
            begin
                wait_idle();
                write_reg(REG_HARD_GOAL_MASK, sparse_mask($urandom_range(4, 1)));
                write_reg(REG_ALL_SOFT, ($urandom() & ~32'd1) | {31'd0, ~soft_reg});
            end
            sender_pause(idle_pct);
            gen_goal_pair(r, s);
            send_goals(r, s);
        end
    endtask

    // an all-ones set swallows every entry, so this stays last
    task automatic test_all_goals_satisfied();
        send_goals(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_goals(32'hFFFF_FFFF, $urandom());
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        reachable_goals = '0;
        satisfied_goals = '0;
        hard_reg = '0;
        soft_reg = 1'b0;
        prune_reg = 1'b1;
        for (i = 0; i < DEPTH; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_set[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_mask_extremes();
        test_hard_goals();
        test_all_soft();
        test_prune_disable();
        test_unmapped_index();
        test_table_overflow();
        test_random_traffic(240, 14, '0, 1'b0, 1'b1);
        test_random_traffic(240, 61, sparse_mask(2), 1'b0, 1'b0);
        test_random_traffic(240, 0, sparse_mask(3), 1'b1, 1'b1);
        test_all_goals_satisfied();

        wait_idle();
        repeat (2 * DEPTH + 8) @(posedge clk);
        $display("Checked %0d transfers over hard/soft/prune settings and a full table.",
                 n_items);
        $display("Inserts %0d, overflows %0d, covered %0d, pruned %0d.",
                 n_inserts, n_overflows, n_covered, n_pruned);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
